// ----- rtl/core/stack_machine_with_roll_top_defines.svh -----
// ----------------------------------------------------------------------------
// Stack machine assertion macros
// Concurrent assertion helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_WITH_ROLL_TOP_DEFINES_SVH
`define STACK_MACHINE_WITH_ROLL_TOP_DEFINES_SVH

// same-cycle implication
`define SMR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/smr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stack machine package
// Sizes, command and status codes, request/result types, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smr_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = 6;

    localparam logic [2:0] MODE_PUSH = 3'd0;
    localparam logic [2:0] MODE_POP  = 3'd1;
    localparam logic [2:0] MODE_SWAP = 3'd2;
    localparam logic [2:0] MODE_ADD  = 3'd3;
    localparam logic [2:0] MODE_ROLL = 3'd4;
    localparam logic [2:0] MODE_LIST = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [WORD_W-1:0] push_value;
    } t_request;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     is_listed;
        logic                     is_last;
        logic [1:0]               status;
        logic [DEPTH_W-1:0]       depth_now;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SW1,
        S_SW2,
        S_SW3,
        S_AD1,
        S_AD2,
        S_RL1,
        S_RL2,
        S_SH,
        S_RL3,
        S_LS,
        S_TOP,
        S_REPLY
    } t_state;

    function automatic logic [DEPTH_W-1:0] to_depth(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+DEPTH_W-1:0] ext;
        ext = {{DEPTH_W{1'b0}}, cnt};
        return ext[DEPTH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/smr_ram.sv -----
// ----------------------------------------------------------------------------
// Stack storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smr_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [smr_pkg::ADDR_W-1:0] i_waddr,
    input  wire logic [smr_pkg::WORD_W-1:0] i_wdata,
    input  wire logic [smr_pkg::ADDR_W-1:0] i_raddr,
    output logic      [smr_pkg::WORD_W-1:0] o_rdata
);

    logic [smr_pkg::WORD_W-1:0] r_mem [smr_pkg::STACK_DEPTH];
    logic [smr_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/stack_machine_with_roll_top.sv -----
// Push, pop and unused modes go from decode through the top-word read to the reply; swap and add first read
// the top two entries, and roll rewrites its n entries one at a time.
// List gives one entry per cycle.
// One request at a time, the next taken in the cycle of the last result.
// The stack RAM and its sequencer set the pace.
// Synchronous active-low reset empties the stack; stored words are not cleared.
// ----------------------------------------------------------------------------
// Stack machine with roll
// Bounded stack of 32-bit words: push, pop, swap, add, roll, list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_with_roll_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire smr_pkg::t_request i_req,
    output logic                   busy,
    output logic                   o_valid,
    output smr_pkg::t_result       o_result
);

    localparam int AW = smr_pkg::ADDR_W;
    localparam int CW = smr_pkg::CNT_W;
    localparam int WW = smr_pkg::WORD_W;

    smr_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [2:0]       r_mode, n_mode;
    logic [WW-1:0]    r_pv, n_pv;
    logic [WW-1:0]    r_a, n_a;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_tgt, n_tgt;
    logic [1:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    smr_pkg::t_result r_out, n_out;

    logic          we;
    logic [AW-1:0] waddr;
    logic [WW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [WW-1:0] rdata;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic [AW-1:0] idx_m1;
    logic [AW-1:0] idx_m2;
    logic [WW-1:0] rem_ext;
    logic [WW-1:0] tgt_full;
    logic          roll_ok;

    assign cnt_m1   = r_cnt - 1'b1;
    assign cnt_m2   = r_cnt - 2'd2;
    assign idx_m1   = r_idx - 1'b1;
    assign idx_m2   = r_idx - 2'd2;
    assign rem_ext  = {{(WW-CW){1'b0}}, cnt_m1};
    assign tgt_full = rem_ext - rdata;
    assign roll_ok  = !rdata[WW-1] && (rdata != '0) && (rdata <= rem_ext);

    smr_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smr_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_pv     <= n_pv;
        r_a      <= n_a;
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_pv        = r_pv;
        n_a         = r_a;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_status    = r_status;
        n_out_valid = 1'b0;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = cnt_m1[AW-1:0];
        wdata       = r_pv;
        raddr       = cnt_m1[AW-1:0];

        case (r_state)
            smr_pkg::S_IDLE: begin
                if (start) begin
                    n_mode  = i_req.mode;
                    n_pv    = i_req.push_value;
                    n_state = smr_pkg::S_DECODE;
                end
            end
            smr_pkg::S_DECODE: begin
                n_status = smr_pkg::ST_DONE;
                n_state  = smr_pkg::S_TOP;
                case (r_mode)
                    smr_pkg::MODE_PUSH: begin
                        if (r_cnt < CW'(smr_pkg::STACK_DEPTH)) begin
                            we    = 1'b1;
                            waddr = r_cnt[AW-1:0];
                            wdata = r_pv;
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            n_status = smr_pkg::ST_FULL;
                        end
                    end
                    smr_pkg::MODE_POP: begin
                        if (r_cnt != '0) begin
                            n_cnt = cnt_m1;
                        end else begin
                            n_status = smr_pkg::ST_FEW;
                        end
                    end
                    smr_pkg::MODE_SWAP: begin
                        if (r_cnt >= CW'(2)) begin
                            n_state = smr_pkg::S_SW1;
                        end else begin
                            n_status = smr_pkg::ST_FEW;
                        end
                    end
                    smr_pkg::MODE_ADD: begin
                        if (r_cnt >= CW'(2)) begin
                            n_state = smr_pkg::S_AD1;
                        end else begin
                            n_status = smr_pkg::ST_FEW;
                        end
                    end
                    smr_pkg::MODE_ROLL: begin
                        if (r_cnt != '0) begin
                            n_state = smr_pkg::S_RL1;
                        end else begin
                            n_status = smr_pkg::ST_FEW;
                        end
                    end
                    smr_pkg::MODE_LIST: begin
                        if (r_cnt != '0) begin
                            n_idx   = cnt_m1[AW-1:0];
                            n_state = smr_pkg::S_LS;
                        end else begin
                            n_status = smr_pkg::ST_FEW;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            smr_pkg::S_SW1: begin
                n_a     = rdata;
                raddr   = cnt_m2[AW-1:0];
                n_state = smr_pkg::S_SW2;
            end
            smr_pkg::S_SW2: begin
                we      = 1'b1;
                waddr   = cnt_m1[AW-1:0];
                wdata   = rdata;
                n_state = smr_pkg::S_SW3;
            end
            smr_pkg::S_SW3: begin
                we      = 1'b1;
                waddr   = cnt_m2[AW-1:0];
                wdata   = r_a;
                n_state = smr_pkg::S_TOP;
            end
            smr_pkg::S_AD1: begin
                n_a     = rdata;
                raddr   = cnt_m2[AW-1:0];
                n_state = smr_pkg::S_AD2;
            end
            smr_pkg::S_AD2: begin
                we      = 1'b1;
                waddr   = cnt_m2[AW-1:0];
                wdata   = r_a + rdata;
                n_cnt   = cnt_m1;
                n_state = smr_pkg::S_TOP;
            end
            smr_pkg::S_RL1: begin
                // rdata is the popped count n
                n_cnt   = cnt_m1;
                n_state = smr_pkg::S_TOP;
                if (!roll_ok) begin
                    n_status = smr_pkg::ST_RANGE;
                end else if (rdata != WW'(1)) begin
                    raddr   = cnt_m2[AW-1:0];
                    n_idx   = cnt_m2[AW-1:0];
                    n_tgt   = tgt_full[AW-1:0];
                    n_state = smr_pkg::S_RL2;
                end
            end
            smr_pkg::S_RL2: begin
                n_a     = rdata;
                raddr   = idx_m1;
                n_state = smr_pkg::S_SH;
            end
            smr_pkg::S_SH: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = rdata;
                if (idx_m1 == r_tgt) begin
                    n_state = smr_pkg::S_RL3;
                end else begin
                    raddr = idx_m2;
                    n_idx = idx_m1;
                end
            end
            smr_pkg::S_RL3: begin
                we      = 1'b1;
                waddr   = r_tgt;
                wdata   = r_a;
                n_state = smr_pkg::S_TOP;
            end
            smr_pkg::S_LS: begin
                n_out_valid     = 1'b1;
                n_out.value     = $signed(rdata);
                n_out.is_listed = 1'b1;
                n_out.is_last   = (r_idx == '0);
                n_out.status    = smr_pkg::ST_DONE;
                n_out.depth_now = smr_pkg::to_depth(r_cnt);
                if (r_idx == '0) begin
                    n_state = smr_pkg::S_IDLE;
                end else begin
                    raddr = idx_m1;
                    n_idx = idx_m1;
                end
            end
            smr_pkg::S_TOP: begin
                n_state = smr_pkg::S_REPLY;
            end
            smr_pkg::S_REPLY: begin
                n_out_valid     = 1'b1;
                n_out.value     = (r_cnt != '0) ? $signed(rdata) : '0;
                n_out.is_listed = 1'b0;
                n_out.is_last   = 1'b1;
                n_out.status    = r_status;
                n_out.depth_now = smr_pkg::to_depth(r_cnt);
                n_state         = smr_pkg::S_IDLE;
            end
            default: begin
                n_state = smr_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != smr_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/smr_checker.sv -----
// ----------------------------------------------------------------------------
// Stack machine port checker
// Watches request and result ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stack_machine_with_roll_top_defines.svh"

module smr_port_assertions (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire smr_pkg::t_result o_result
);

    `SMR_ASSERT_NEXT(a_busy_after_req, start && !busy, busy, "busy low after request")
    `SMR_ASSERT_NOW(a_reply_is_last, o_valid && !o_result.is_listed,
                    o_result.is_last, "reply not last")
    `SMR_ASSERT_NEXT(a_list_streams, o_valid && o_result.is_listed && !o_result.is_last,
                     o_valid, "list gap")
    `SMR_ASSERT_NOW(a_last_frees, o_valid && o_result.is_last, !busy, "busy after last result")

endmodule

bind stack_machine_with_roll_top smr_port_assertions u_smr_port_assertions (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
